[hdl/lsrd_pkg.sv]
`default_nettype none
package lsrd_pkg;

   localparam int COORD_W    = 24;
   localparam int IDX_W      = 12;
   localparam int SHIFT_W    = 5;
   localparam int DEMAND_W   = 16;
   localparam int CELL_W     = 32;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 48;
   localparam int CROSS_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int BOUND_W    = 44;

   localparam int DEF_COLUMNS = 64;
   localparam int DEF_ROWS    = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LOG = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEMAND    = 3'd4;

   localparam logic CMD_ROUTE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [COORD_W-1:0] sink_x;
      logic [COORD_W-1:0] sink_y;
      logic [IDX_W-1:0]   cell_index;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  origin_x;
      logic [COORD_W-1:0]  origin_y;
      logic [SHIFT_W-1:0]  width_log2;
      logic [SHIFT_W-1:0]  height_log2;
      logic [DEMAND_W-1:0] demand;
   } cfg_type;

   // true when either leg of the L touches the cell [lft,rgt) x [bot,tp)
   function automatic logic touches(req_type r, logic [BOUND_W-1:0] lft,
                                    logic [BOUND_W-1:0] rgt, logic [BOUND_W-1:0] bot,
                                    logic [BOUND_W-1:0] tp);
      logic [BOUND_W-1:0] sx;
      logic [BOUND_W-1:0] sy;
      logic [BOUND_W-1:0] tx;
      logic [BOUND_W-1:0] ty;
      logic [BOUND_W-1:0] hlo;
      logic [BOUND_W-1:0] hhi;
      logic [BOUND_W-1:0] vlo;
      logic [BOUND_W-1:0] vhi;
      logic               leg_h;
      logic               leg_v;
      sx  = BOUND_W'(r.source_x);
      sy  = BOUND_W'(r.source_y);
      tx  = BOUND_W'(r.sink_x);
      ty  = BOUND_W'(r.sink_y);
      hlo = (sx < tx) ? sx : tx;
      hhi = (sx < tx) ? tx : sx;
      vlo = (sy < ty) ? sy : ty;
      vhi = (sy < ty) ? ty : sy;
      leg_h = (sy >= bot && sy < tp && hhi > lft && hlo < rgt) ||
              (sx == tx && sx >= lft && sx < rgt && sy > bot && sy < tp);
      leg_v = (tx >= lft && tx < rgt && vhi > bot && vlo < tp) ||
              (sy == ty && sy >= bot && sy < tp && tx > lft && tx < rgt);
      return leg_h || leg_v;
   endfunction

endpackage
`default_nettype wire

[hdl/lsrd_front.sv]
`default_nettype none
module lsrd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept_en,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lsrd_pkg::req_type req_item,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output lsrd_pkg::req_type      q_item
);
   import lsrd_pkg::*;

   req_type     entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push;
   logic        pop;

   assign req_ready = accept_en && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

[hdl/lsrd_back.sv]
`default_nettype none
module lsrd_back #(
   parameter int GRID_COLUMNS = lsrd_pkg::DEF_COLUMNS,
   parameter int GRID_ROWS    = lsrd_pkg::DEF_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lsrd_pkg::cfg_type             cfg,
   output logic                               clearing,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   input  wire lsrd_pkg::req_type             q_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lsrd_pkg::CROSS_W-1:0]       rsp_crossed_count,
   output logic                               rsp_route_taken,
   output logic [lsrd_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic [lsrd_pkg::CNT_W-1:0]         rsp_routed_total,
   output logic [lsrd_pkg::CNT_W-1:0]         rsp_skipped_total,
   output logic [lsrd_pkg::SUM_W-1:0]         rsp_demand_total
);
   import lsrd_pkg::*;

   localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MAXD  = (GRID_COLUMNS > GRID_ROWS) ? GRID_COLUMNS : GRID_ROWS;
   localparam int IW    = $clog2(MAXD + 1);
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOCATE, ST_SETUP, ST_HSCAN, ST_VSCAN,
      ST_WRITE, ST_TALLY, ST_RDCMD, ST_FINISH
   } state_type;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [BOUND_W-1:0] lft_ff, lft_in;
   logic [BOUND_W-1:0] bot_ff, bot_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [IW-1:0]      rs_ff, rs_in;
   logic [IW-1:0]      ct_ff, ct_in;
   logic               rs_ok_ff, rs_ok_in;
   logic               ct_ok_ff, ct_ok_in;
   logic [BOUND_W-1:0] rs_bot_ff, rs_bot_in;
   logic [AW-1:0]      rs_base_ff, rs_base_in;
   logic [BOUND_W-1:0] ct_lft_ff, ct_lft_in;
   logic               ret_v_ff, ret_v_in;
   logic               in_range_ff, in_range_in;
   logic [CROSS_W-1:0] crossed_ff, crossed_in;
   logic [CELL_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]   routed_ff, routed_in;
   logic [CNT_W-1:0]   skipped_ff, skipped_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CROSS_W-1:0] rsp_crossed_ff, rsp_crossed_in;
   logic               rsp_taken_ff, rsp_taken_in;
   logic [CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]   rsp_routed_ff, rsp_routed_in;
   logic [CNT_W-1:0]   rsp_skipped_ff, rsp_skipped_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic [BOUND_W-1:0] cw;
   logic [BOUND_W-1:0] ch;
   logic [BOUND_W-1:0] cur_lft;
   logic [BOUND_W-1:0] cur_bot;
   logic               hit;
   logic               is_v;
   logic               adv;
   logic               col_hit;
   logic               row_hit;
   logic [CELL_W:0]    cell_sum;
   logic [SUM_W:0]     total_sum;
   logic [BOUND_W-1:0] txw;
   logic [BOUND_W-1:0] syw;

   assign cw  = {{(BOUND_W-1){1'b0}}, 1'b1} << cfg.width_log2;
   assign ch  = {{(BOUND_W-1){1'b0}}, 1'b1} << cfg.height_log2;
   assign txw = BOUND_W'(item_ff.sink_x);
   assign syw = BOUND_W'(item_ff.source_y);

   assign is_v    = (state_ff == ST_VSCAN) || (state_ff == ST_WRITE && ret_v_ff);
   assign cur_lft = is_v ? ct_lft_ff : lft_ff;
   assign cur_bot = is_v ? bot_ff : rs_bot_ff;
   assign hit     = touches(item_ff, cur_lft, cur_lft + cw, cur_bot, cur_bot + ch);
   assign col_hit = (i_ff < IW'(GRID_COLUMNS)) && txw >= lft_ff && txw < lft_ff + cw;
   assign row_hit = (i_ff < IW'(GRID_ROWS)) && syw >= bot_ff && syw < bot_ff + ch;

   assign cell_sum  = {1'b0, rdata_ff} + (CELL_W + 1)'(cfg.demand);
   assign total_sum = {1'b0, sum_ff} + (SUM_W + 1)'(cfg.demand);

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      addr_in        = addr_ff;
      i_in           = i_ff;
      lft_in         = lft_ff;
      bot_in         = bot_ff;
      base_in        = base_ff;
      rs_in          = rs_ff;
      ct_in          = ct_ff;
      rs_ok_in       = rs_ok_ff;
      ct_ok_in       = ct_ok_ff;
      rs_bot_in      = rs_bot_ff;
      rs_base_in     = rs_base_ff;
      ct_lft_in      = ct_lft_ff;
      ret_v_in       = ret_v_ff;
      in_range_in    = in_range_ff;
      crossed_in     = crossed_ff;
      value_in       = value_ff;
      routed_in      = routed_ff;
      skipped_in     = skipped_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_crossed_in = rsp_crossed_ff;
      rsp_taken_in   = rsp_taken_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_routed_in  = rsp_routed_ff;
      rsp_skipped_in = rsp_skipped_ff;
      rsp_sum_in     = rsp_sum_ff;
      mem_we         = 1'b0;
      mem_wa         = addr_ff;
      mem_wd         = cell_sum[CELL_W] ? {CELL_W{1'b1}} : cell_sum[CELL_W-1:0];
      rd_en          = 1'b0;
      rd_addr        = addr_ff;
      q_pop          = 1'b0;
      adv            = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            mem_wd  = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(CELLS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               item_in    = q_item;
               crossed_in = '0;
               value_in   = '0;
               if (q_item.command == CMD_READ) begin
                  rd_en       = 1'b1;
                  rd_addr     = AW'(q_item.cell_index);
                  in_range_in = (32'(q_item.cell_index) < 32'(CELLS));
                  state_in    = ST_RDCMD;
               end else begin
                  i_in     = '0;
                  lft_in   = BOUND_W'(cfg.origin_x);
                  bot_in   = BOUND_W'(cfg.origin_y);
                  base_in  = '0;
                  rs_ok_in = 1'b0;
                  ct_ok_in = 1'b0;
                  state_in = ST_LOCATE;
               end
            end
         end
         ST_LOCATE: begin
            if (col_hit) begin
               ct_in     = i_ff;
               ct_ok_in  = 1'b1;
               ct_lft_in = lft_ff;
            end
            if (row_hit) begin
               rs_in      = i_ff;
               rs_ok_in   = 1'b1;
               rs_bot_in  = bot_ff;
               rs_base_in = base_ff;
            end
            i_in    = i_ff + 1'b1;
            lft_in  = lft_ff + cw;
            bot_in  = bot_ff + ch;
            base_in = base_ff + AW'(GRID_COLUMNS);
            if (i_ff == IW'(MAXD - 1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            i_in = '0;
            if (rs_ok_ff) begin
               lft_in   = BOUND_W'(cfg.origin_x);
               addr_in  = rs_base_ff;
               state_in = ST_HSCAN;
            end else if (ct_ok_ff) begin
               bot_in   = BOUND_W'(cfg.origin_y);
               addr_in  = AW'(ct_ff);
               state_in = ST_VSCAN;
            end else begin
               state_in = ST_TALLY;
            end
         end
         ST_HSCAN: begin
            if (hit) begin
               rd_en    = 1'b1;
               ret_v_in = 1'b0;
               state_in = ST_WRITE;
            end else begin
               adv = 1'b1;
            end
         end
         ST_VSCAN: begin
            if (hit && !(rs_ok_ff && i_ff == rs_ff)) begin
               rd_en    = 1'b1;
               ret_v_in = 1'b1;
               state_in = ST_WRITE;
            end else begin
               adv = 1'b1;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            sum_in = total_sum[SUM_W] ? SUM_MAX : total_sum[SUM_W-1:0];
            if (crossed_ff != {CROSS_W{1'b1}}) begin
               crossed_in = crossed_ff + 1'b1;
            end
            adv = 1'b1;
         end
         ST_TALLY: begin
            if (crossed_ff == '0) begin
               if (skipped_ff != {CNT_W{1'b1}}) begin
                  skipped_in = skipped_ff + 1'b1;
               end
            end else if (routed_ff != {CNT_W{1'b1}}) begin
               routed_in = routed_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_RDCMD: begin
            value_in = in_range_ff ? rdata_ff : '0;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_crossed_in = crossed_ff;
               rsp_taken_in   = (crossed_ff != '0);
               rsp_value_in   = value_ff;
               rsp_routed_in  = routed_ff;
               rsp_skipped_in = skipped_ff;
               rsp_sum_in     = sum_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next cell of the current leg, or at the end of the row go on to the sink column or the tally
      if (adv) begin
         if (!is_v) begin
            if (i_ff == IW'(GRID_COLUMNS - 1)) begin
               if (ct_ok_ff) begin
                  i_in     = '0;
                  bot_in   = BOUND_W'(cfg.origin_y);
                  addr_in  = AW'(ct_ff);
                  state_in = ST_VSCAN;
               end else begin
                  state_in = ST_TALLY;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               lft_in   = lft_ff + cw;
               addr_in  = addr_ff + 1'b1;
               state_in = ST_HSCAN;
            end
         end else begin
            if (i_ff == IW'(GRID_ROWS - 1)) begin
               state_in = ST_TALLY;
            end else begin
               i_in     = i_ff + 1'b1;
               bot_in   = bot_ff + ch;
               addr_in  = addr_ff + AW'(GRID_COLUMNS);
               state_in = ST_VSCAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      i_ff           <= i_in;
      lft_ff         <= lft_in;
      bot_ff         <= bot_in;
      base_ff        <= base_in;
      rs_ff          <= rs_in;
      ct_ff          <= ct_in;
      rs_ok_ff       <= rs_ok_in;
      ct_ok_ff       <= ct_ok_in;
      rs_bot_ff      <= rs_bot_in;
      rs_base_ff     <= rs_base_in;
      ct_lft_ff      <= ct_lft_in;
      ret_v_ff       <= ret_v_in;
      in_range_ff    <= in_range_in;
      crossed_ff     <= crossed_in;
      value_ff       <= value_in;
      rsp_crossed_ff <= rsp_crossed_in;
      rsp_taken_ff   <= rsp_taken_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_routed_ff  <= rsp_routed_in;
      rsp_skipped_ff <= rsp_skipped_in;
      rsp_sum_ff     <= rsp_sum_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         routed_ff    <= '0;
         skipped_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         routed_ff    <= routed_in;
         skipped_ff   <= skipped_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign clearing          = (state_ff == ST_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_crossed_count = rsp_crossed_ff;
   assign rsp_route_taken   = rsp_taken_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_routed_total  = rsp_routed_ff;
   assign rsp_skipped_total = rsp_skipped_ff;
   assign rsp_demand_total  = rsp_sum_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !q_pop)
      else $error("queue popped during clearing pass");

   a_taken_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_taken_ff == (rsp_crossed_ff != '0)))
      else $error("route_taken disagrees with crossed_count");

   a_route_has_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_taken_ff |-> rsp_value_ff == '0)
      else $error("routed result carries a cell value");

   a_routed_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> routed_ff >= $past(routed_ff))
      else $error("routed counter went down");

endmodule
`default_nettype wire

[hdl/l_shape_route_demand_grid_unit.sv]
// read command: popped from the queue with the cell read issued, then latched, then registered as the result
// route command: a locate pass over max(cols, rows) positions, then a walk of the source row and sink column
// the back end takes one request at a time, walking the source row and sink column with
// one read-modify-write per touched cell on the single demand memory
// reset: a clearing pass zeroes all GRID_COLUMNS * GRID_ROWS cells, req_ready low meanwhile
`default_nettype none
module l_shape_route_demand_grid_unit #(
   parameter int GRID_COLUMNS = lsrd_pkg::DEF_COLUMNS,
   parameter int GRID_ROWS    = lsrd_pkg::DEF_ROWS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [lsrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsrd_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [lsrd_pkg::COORD_W-1:0]    req_source_x,
   input  wire logic [lsrd_pkg::COORD_W-1:0]    req_source_y,
   input  wire logic [lsrd_pkg::COORD_W-1:0]    req_sink_x,
   input  wire logic [lsrd_pkg::COORD_W-1:0]    req_sink_y,
   input  wire logic [lsrd_pkg::IDX_W-1:0]      req_cell_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [lsrd_pkg::CROSS_W-1:0]         rsp_crossed_count,
   output logic                                 rsp_route_taken,
   output logic [lsrd_pkg::CELL_W-1:0]          rsp_cell_value,
   output logic [lsrd_pkg::CNT_W-1:0]           rsp_routed_total,
   output logic [lsrd_pkg::CNT_W-1:0]           rsp_skipped_total,
   output logic [lsrd_pkg::SUM_W-1:0]           rsp_demand_total
);
   import lsrd_pkg::*;

   cfg_type cfg_ff;
   req_type req_item;
   req_type q_item;
   logic    q_valid;
   logic    q_pop;
   logic    clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.width_log2  <= SHIFT_W'(10);
         cfg_ff.height_log2 <= SHIFT_W'(10);
         cfg_ff.demand      <= DEMAND_W'(256);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   cfg_ff.origin_x    <= csr_write_data;
            CSR_ORIGIN_Y:   cfg_ff.origin_y    <= csr_write_data;
            CSR_WIDTH_LOG:  cfg_ff.width_log2  <= csr_write_data[SHIFT_W-1:0];
            CSR_HEIGHT_LOG: cfg_ff.height_log2 <= csr_write_data[SHIFT_W-1:0];
            CSR_DEMAND:     cfg_ff.demand      <= csr_write_data[DEMAND_W-1:0];
            default:        cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign req_item = '{command:    req_command,
                       source_x:   req_source_x,
                       source_y:   req_source_y,
                       sink_x:     req_sink_x,
                       sink_y:     req_sink_y,
                       cell_index: req_cell_index};

   lsrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (!clearing),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   lsrd_back #(
      .GRID_COLUMNS (GRID_COLUMNS),
      .GRID_ROWS    (GRID_ROWS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .clearing          (clearing),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_item            (q_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_crossed_count (rsp_crossed_count),
      .rsp_route_taken   (rsp_route_taken),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_routed_total  (rsp_routed_total),
      .rsp_skipped_total (rsp_skipped_total),
      .rsp_demand_total  (rsp_demand_total)
   );

endmodule
`default_nettype wire
